### design/ircms_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the ir carrier mark/space sender
package ircms_pkg;

    localparam int DurationBits = 16;
    localparam int FreqBits     = 20;
    localparam int DutyBits     = 7;
    localparam int OffsetBits   = 8;
    localparam int PulseBits    = 16;
    localparam int DivNBits     = 27;
    localparam int DivDBits     = 20;
    localparam int DivCntBits   = 5;
    localparam int RecipBits    = 26;
    localparam int DutyShift    = 32;

    localparam logic [DutyBits-1:0]   DUTY_FULL   = 7'd100;
    localparam logic [FreqBits-1:0]   KHZ_LIMIT   = 20'd1000;
    localparam logic [9:0]            KHZ_SCALE   = 10'd1000;
    localparam logic [FreqBits:0]     ONE_MHZ     = 21'd1000000;
    localparam logic [PulseBits-1:0]  PULSE_MAX   = 16'hFFFF;
    // multiply and shift right by DutyShift to divide by 100, exact below 2^27
    localparam logic [RecipBits-1:0]  DUTY_RECIP  = 26'd42949673;

    localparam int AddrBits = 5;
    localparam logic [2:0] REG_FREQ   = 3'd0;
    localparam logic [2:0] REG_DUTY   = 3'd1;
    localparam logic [2:0] REG_MOD_EN = 3'd2;
    localparam logic [2:0] REG_INVERT = 3'd3;
    localparam logic [2:0] REG_OFFSET = 3'd4;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_PUSH  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_PUSH,
        CMD_START,
        CMD_NOP
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV_PERIOD,
        BK_MULT,
        BK_DIV_DUTY
    } t_back_state;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [DurationBits-1:0] duration;
    } t_in_item;

    typedef struct packed {
        logic                 pin_level;
        logic                 busy_res;
        logic                 accepted;
        logic                 in_mark;
        logic [PulseBits-1:0] pulse_count;
    } t_out_res;

    typedef struct packed {
        t_cmd                    cmd;
        logic [DurationBits-1:0] duration;
    } t_cmd_entry;

    typedef struct packed {
        logic [FreqBits-1:0]          freq;
        logic [DutyBits-1:0]          duty;
        logic                         mod_en;
        logic                         invert;
        logic signed [OffsetBits-1:0] offset;
    } t_cfg;

endpackage

### design/ircms_front.sv
`timescale 1ns / 1ps
// front stage: takes input items and classifies the opcode into a command
module ircms_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ircms_pkg::t_in_item   i_item,
    output logic                  o_stall,
    output logic                  o_push,
    output ircms_pkg::t_cmd_entry o_entry,
    input  logic                  i_q_full
);
    import ircms_pkg::*;

    logic       r_valid;
    t_cmd_entry r_entry;
    t_cmd       n_cmd;
    logic       accept;

    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_q_full;
    assign o_entry = r_entry;

    always_comb begin
        unique case (i_item.opcode)
            OP_TICK:  n_cmd = CMD_TICK;
            OP_PUSH:  n_cmd = CMD_PUSH;
            OP_START: n_cmd = CMD_START;
            default:  n_cmd = CMD_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry.cmd      <= n_cmd;
            r_entry.duration <= i_item.duration;
        end
    end

endmodule

### design/ircms_queue.sv
`timescale 1ns / 1ps
// short command queue between the front stage and the execution back end
module ircms_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ircms_pkg::t_cmd_entry i_entry,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output ircms_pkg::t_cmd_entry o_entry
);
    import ircms_pkg::*;

    localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntBits = $clog2(DEPTH + 1);
    localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);
    localparam logic [CntBits-1:0] FullCnt = CntBits'(DEPTH);

    t_cmd_entry         r_mem [DEPTH];
    logic [PtrBits-1:0] r_wr_ptr;
    logic [PtrBits-1:0] r_rd_ptr;
    logic [CntBits-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == FullCnt);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### design/ircms_divider.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module ircms_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [ircms_pkg::DivNBits-1:0]      i_dividend,
    input  logic [ircms_pkg::DivDBits-1:0]      i_divisor,
    output logic                                o_done,
    output logic [ircms_pkg::DivNBits-1:0]      o_quotient
);
    import ircms_pkg::*;

    localparam logic [DivCntBits-1:0] LastStep = DivCntBits'(DivNBits - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [DivCntBits-1:0] r_cnt;
    logic [DivNBits-1:0]   r_quot;
    logic [DivDBits-1:0]   r_rem;
    logic [DivDBits-1:0]   r_div;
    logic [DivDBits:0]     trial;
    logic                  qbit;
    logic [DivDBits-1:0]   n_rem;

    assign o_done     = r_done;
    assign o_quotient = r_quot;

    always_comb begin
        trial = {r_rem, r_quot[DivNBits-1]};
        qbit  = (trial >= {1'b0, r_div});
        n_rem = qbit ? DivDBits'(trial - {1'b0, r_div}) : trial[DivDBits-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_cnt == LastStep) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '0;
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_quot <= {r_quot[DivNBits-2:0], qbit};
            r_rem  <= n_rem;
        end
    end

endmodule

### design/ircms_back.sv
`timescale 1ns / 1ps
// back end: runs ticks, pushes and carrier setup, holds the result register
module ircms_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ircms_pkg::t_cfg       i_cfg,
    input  logic                  i_q_valid,
    input  ircms_pkg::t_cmd_entry i_q_entry,
    output logic                  o_q_pop,
    output logic                  o_valid,
    output ircms_pkg::t_out_res   o_res,
    input  logic                  i_stall
);
    import ircms_pkg::*;

    t_back_state             r_state, n_state;
    logic [DurationBits-1:0] r_rem, n_rem;
    logic [FreqBits-1:0]     r_phase, n_phase;
    logic [FreqBits-1:0]     r_on, n_on;
    logic [FreqBits-1:0]     r_off, n_off;
    logic [FreqBits-1:0]     r_period, n_period;
    logic [DivNBits-1:0]     r_prod, n_prod;
    logic                    r_mark, n_mark;
    logic                    r_expect, n_expect;
    logic [PulseBits-1:0]    r_pulses, n_pulses;
    logic                    r_out_valid;
    t_out_res                r_out, n_out;

    logic                    out_free;
    logic                    load_out;
    logic                    acc;
    logic                    solid_cur;
    logic                    solid_next;
    logic                    active;
    logic [FreqBits-1:0]     freq_khz;
    logic [FreqBits-1:0]     freq_eff;
    logic [FreqBits-1:0]     phase_inc;
    logic [FreqBits:0]       cur_period;
    logic signed [21:0]      per_s;
    logic [DutyBits-1:0]     duty_eff;
    logic [DivNBits+RecipBits-1:0] duty_scaled;
    logic                    div_start;
    logic [DivNBits-1:0]     div_dividend;
    logic [DivDBits-1:0]     div_divisor;
    logic                    div_done;
    logic [DivNBits-1:0]     div_q;

    ircms_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    always_comb begin
        freq_khz  = {10'd0, i_cfg.freq[9:0]} * {10'd0, KHZ_SCALE};
        freq_eff  = (i_cfg.freq < KHZ_LIMIT) ? freq_khz : i_cfg.freq;
        if (freq_eff == '0) begin
            freq_eff = 20'd1;
        end
        if (!i_cfg.mod_en) begin
            duty_eff = DUTY_FULL;
        end else begin
            duty_eff = (i_cfg.duty < DUTY_FULL) ? i_cfg.duty : DUTY_FULL;
        end
        per_s      = $signed({2'b00, div_q[FreqBits-1:0]})
                   + $signed({{14{i_cfg.offset[OffsetBits-1]}}, i_cfg.offset});
        // period times duty divided by 100 through the reciprocal
        duty_scaled = {{RecipBits{1'b0}}, r_prod} * {{DivNBits{1'b0}}, DUTY_RECIP};
        solid_cur  = !i_cfg.mod_en || (r_off == '0);
        cur_period = {1'b0, r_on} + {1'b0, r_off};
        phase_inc  = r_phase + 1'b1;
    end

    always_comb begin
        n_state      = r_state;
        n_rem        = r_rem;
        n_phase      = r_phase;
        n_on         = r_on;
        n_off        = r_off;
        n_period     = r_period;
        n_prod       = r_prod;
        n_mark       = r_mark;
        n_expect     = r_expect;
        n_pulses     = r_pulses;
        o_q_pop      = 1'b0;
        load_out     = 1'b0;
        acc          = 1'b0;
        div_start    = 1'b0;
        div_dividend = DivNBits'(ONE_MHZ + {2'b00, freq_eff[FreqBits-1:1]});
        div_divisor  = freq_eff;

        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    case (i_q_entry.cmd)
                        CMD_START: begin
                            div_start = 1'b1;
                            n_state   = BK_DIV_PERIOD;
                        end
                        CMD_PUSH: begin
                            load_out = 1'b1;
                            if (r_rem == '0) begin
                                acc     = 1'b1;
                                n_rem   = i_q_entry.duration;
                                n_phase = '0;
                                if (!r_expect) begin
                                    n_pulses = (solid_cur || i_q_entry.duration != '0)
                                             ? PulseBits'(1) : '0;
                                    n_mark   = (i_q_entry.duration != '0);
                                end else begin
                                    n_mark = 1'b0;
                                end
                                n_expect = !r_expect;
                            end
                        end
                        CMD_TICK: begin
                            load_out = 1'b1;
                            if (r_rem != '0) begin
                                n_rem = r_rem - 1'b1;
                                if (n_rem == '0) begin
                                    n_mark = 1'b0;
                                end else if (r_mark && !solid_cur) begin
                                    // carrier wraps once a full period has elapsed
                                    if ({1'b0, phase_inc} >= cur_period) begin
                                        n_phase = '0;
                                        if (r_pulses != PULSE_MAX) begin
                                            n_pulses = r_pulses + 1'b1;
                                        end
                                    end else begin
                                        n_phase = phase_inc;
                                    end
                                end
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            BK_DIV_PERIOD: begin
                if (div_done) begin
                    n_period = (per_s < 22'sd1) ? 20'd1 : per_s[FreqBits-1:0];
                    n_state  = BK_MULT;
                end
            end
            BK_MULT: begin
                n_prod  = DivNBits'(r_period) * DivNBits'(duty_eff);
                n_state = BK_DIV_DUTY;
            end
            BK_DIV_DUTY: begin
                if (out_free) begin
                    n_on     = duty_scaled[DutyShift +: FreqBits];
                    n_off    = r_period - duty_scaled[DutyShift +: FreqBits];
                    n_rem    = '0;
                    n_phase  = '0;
                    n_mark   = 1'b0;
                    n_expect = 1'b0;
                    n_pulses = '0;
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        solid_next = !i_cfg.mod_en || (n_off == '0);
        active     = n_mark && (n_rem != '0) && (solid_next || n_phase < n_on);
        n_out.pin_level   = active ^ i_cfg.invert;
        n_out.busy_res    = (n_rem != '0);
        n_out.accepted    = acc;
        n_out.in_mark     = n_mark;
        n_out.pulse_count = n_pulses;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_rem       <= '0;
            r_phase     <= '0;
            r_on        <= '0;
            r_off       <= '0;
            r_mark      <= 1'b0;
            r_expect    <= 1'b0;
            r_pulses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rem    <= n_rem;
            r_phase  <= n_phase;
            r_on     <= n_on;
            r_off    <= n_off;
            r_mark   <= n_mark;
            r_expect <= n_expect;
            r_pulses <= n_pulses;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_period <= n_period;
        r_prod   <= n_prod;
        if (load_out) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_mark_needs_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mark |-> (r_rem != '0))
        else $error("mark active with no time left");

    a_phase_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cur_period != '0) |-> ({1'b0, r_phase} < cur_period))
        else $error("carrier phase beyond period");

    a_idle_result_no_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.busy_res) |-> !r_out.in_mark)
        else $error("result reports mark while not busy");

    a_start_enters_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_entry.cmd == CMD_START) |=> (r_state == BK_DIV_PERIOD))
        else $error("start did not launch the period division");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_IDLE) |-> !o_q_pop)
        else $error("queue popped during carrier setup");
`endif

endmodule

### design/ir_carrier_mark_space_sender.sv
`timescale 1ns / 1ps
// top level: config registers, front stage, command queue and back end
//
// channel   direction  handshake                     payload
// input     in         i_in_valid / o_in_stall       i_in_item  (opcode, duration)
// output    out        o_out_valid / i_out_stall     o_out_res  (pin, busy, acc, mark, pulses)
// config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// tick, push and unused opcodes are handled by the back end once at the queue head.
// a start holds the back end after the pop through 27 steps of the bit-serial
// divider for the period, one to clamp it, one to multiply by the duty and one to
// scale by the reciprocal of 100, which also waits for a free result register.
// reset restores the register defaults and clears all interval state; no sweep.
// the front stage keeps taking items while the queue has room; the back end
// waits, apart from carrier setup, only when the result register is still held by a stalled receiver.
module ir_carrier_mark_space_sender #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  ircms_pkg::t_in_item                i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output ircms_pkg::t_out_res                o_out_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ircms_pkg::AddrBits-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import ircms_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_wr;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    t_cmd_entry front_entry;
    t_cmd_entry q_entry;

    assign pready  = 1'b1;
    assign reg_idx = paddr[AddrBits-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq   <= 20'd38000;
            r_cfg.duty   <= 7'd50;
            r_cfg.mod_en <= 1'b1;
            r_cfg.invert <= 1'b0;
            r_cfg.offset <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FREQ:   r_cfg.freq   <= pwdata[FreqBits-1:0];
                REG_DUTY:   r_cfg.duty   <= pwdata[DutyBits-1:0];
                REG_MOD_EN: r_cfg.mod_en <= pwdata[0];
                REG_INVERT: r_cfg.invert <= pwdata[0];
                REG_OFFSET: r_cfg.offset <= pwdata[OffsetBits-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FREQ:   prdata = 32'(r_cfg.freq);
            REG_DUTY:   prdata = 32'(r_cfg.duty);
            REG_MOD_EN: prdata = 32'(r_cfg.mod_en);
            REG_INVERT: prdata = 32'(r_cfg.invert);
            REG_OFFSET: prdata = {24'd0, r_cfg.offset};
            default:    prdata = '0;
        endcase
    end

    ircms_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_item   (i_in_item),
        .o_stall  (o_in_stall),
        .o_push   (q_push),
        .o_entry  (front_entry),
        .i_q_full (q_full)
    );

    ircms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    ircms_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_q_pop   (q_pop),
        .o_valid   (o_out_valid),
        .o_res     (o_out_res),
        .i_stall   (i_out_stall)
    );

endmodule

### bench/tb_ir_carrier_mark_space_sender.sv
`timescale 1ns / 1ps
// self-checking bench for the ir carrier mark/space sender
module tb_ir_carrier_mark_space_sender;
    import ircms_pkg::*;

    localparam int CLK_HI      = 6;
    localparam int CLK_LO      = 6;
    localparam int RST_CYCLES  = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int N_DIRECTED  = 25;
    localparam int N_PHASES    = 9;
    localparam int PHASE_ITEMS = 125;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_in_item item;
        logic     typed;
        t_out_res res;
    } t_stim_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    t_in_item              in_item    = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    t_out_res              out_res;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [AddrBits-1:0]   paddr      = '0;
    logic [31:0]           pwdata     = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // register copy and interval state of the predictor
    t_cfg                  regs;
    logic [15:0]           rem_us;
    logic [15:0]           pulse_cnt;
    logic [19:0]           phase_us;
    logic [19:0]           on_us;
    logic [19:0]           off_us;
    logic                  mark_on;
    logic                  space_next;

    t_out_res              pin_status_q[$];
    t_stim_row             stim_q[$];
    int                    err_count      = 0;
    int                    cycle_count    = 0;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;

    // directed rows: typed results where they are obvious, zero res otherwise
    t_stim_row dir_tab [N_DIRECTED] = '{
        '{'{OP_TICK,  16'd0},      1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0}},
        '{'{CMD_NOP,  16'hFFFF},   1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0}},
        '{'{OP_PUSH,  16'd0},      1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 16'd1}},
        '{'{OP_PUSH,  16'd2},      1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 16'd1}},
        '{'{OP_PUSH,  16'd9},      1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 16'd1}},
        '{'{OP_TICK,  16'd0},      1'b0, '0},
        '{'{OP_TICK,  16'd0},      1'b0, '0},
        '{'{OP_PUSH,  16'hFFFF},   1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, 16'd1}},
        '{'{OP_TICK,  16'd0},      1'b0, '0},
        '{'{OP_START, 16'd0},      1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0}},
        '{'{OP_PUSH,  16'd0},      1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 16'd0}},
        '{'{OP_PUSH,  16'd0},      1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 16'd0}},
        '{'{OP_PUSH,  16'd9},      1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, 16'd1}},
        '{'{OP_TICK,  16'd0},      1'b0, '0},
        '{'{OP_TICK,  16'd0},      1'b0, '0},
        '{'{OP_TICK,  16'd0},      1'b0, '0},
        '{'{OP_TICK,  16'd0},      1'b0, '0},
        '{'{OP_TICK,  16'd0},      1'b0, '0},
        '{'{OP_TICK,  16'd0},      1'b0, '0},
        '{'{OP_TICK,  16'd0},      1'b0, '0},
        '{'{OP_TICK,  16'd0},      1'b0, '0},
        '{'{OP_TICK,  16'd0},      1'b0, '0},
        '{'{OP_PUSH,  16'hFFFF},   1'b0, '0},
        '{'{OP_TICK,  16'd0},      1'b0, '0},
        '{'{OP_START, 16'd0},      1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'd0}}
    };

    ir_carrier_mark_space_sender i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_res   (out_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #CLK_HI i_clk = 1'b1;
        #CLK_LO i_clk = 1'b0;
    end

    function automatic logic solid_now();
        return !regs.mod_en || off_us == 20'd0;
    endfunction

    function automatic void setup_carrier();
        longint f;
        longint per;
        longint duty;
        longint on_l;
        f = longint'(regs.freq);
        if (f < longint'(KHZ_LIMIT)) f = f * longint'(KHZ_SCALE);
        if (f == 0) f = 1;
        per = (longint'(ONE_MHZ) + f / 2) / f + longint'(regs.offset);
        if (per < 1) per = 1;
        duty = longint'(DUTY_FULL);
        if (regs.mod_en && regs.duty < DUTY_FULL) duty = longint'(regs.duty);
        on_l = per * duty / longint'(DUTY_FULL);
        on_us      = 20'(on_l);
        off_us     = 20'(per - on_l);
        rem_us     = '0;
        phase_us   = '0;
        mark_on    = 1'b0;
        space_next = 1'b0;
        pulse_cnt  = '0;
    endfunction

    // advances the predicted sender by one item and returns its status
    function automatic t_out_res sender_step(t_in_item it);
        t_out_res   r;
        logic [20:0] per;
        logic       act;
        r = '0;
        case (it.opcode)
            OP_START: setup_carrier();
            OP_PUSH: begin
                if (rem_us == '0) begin
                    r.accepted = 1'b1;
                    rem_us     = it.duration;
                    phase_us   = '0;
                    if (!space_next) begin
                        pulse_cnt = (solid_now() || it.duration != '0) ? 16'd1 : 16'd0;
                        mark_on   = it.duration != '0;
                    end else begin
                        mark_on = 1'b0;
                    end
                    space_next = !space_next;
                end
            end
            OP_TICK: begin
                if (rem_us != '0) begin
                    rem_us = rem_us - 16'd1;
                    if (rem_us == '0) begin
                        mark_on = 1'b0;
                    end else if (mark_on && !solid_now()) begin
                        per      = {1'b0, on_us} + {1'b0, off_us};
                        phase_us = phase_us + 20'd1;
                        if ({1'b0, phase_us} >= per) begin
                            phase_us = '0;
                            if (pulse_cnt != PULSE_MAX) pulse_cnt = pulse_cnt + 16'd1;
                        end
                    end
                end
            end
            default: ;
        endcase
        act = mark_on && rem_us != '0 && (solid_now() || phase_us < on_us);
        r.pin_level   = act ^ regs.invert;
        r.busy_res    = rem_us != '0;
        r.in_mark     = mark_on;
        r.pulse_count = pulse_cnt;
        return r;
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FREQ:   regs.freq   = val[FreqBits-1:0];
            REG_DUTY:   regs.duty   = val[DutyBits-1:0];
            REG_MOD_EN: regs.mod_en = val[0];
            REG_INVERT: regs.invert = val[0];
            REG_OFFSET: regs.offset = val[OffsetBits-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(t_cfg c);
        reg_write(REG_FREQ,   {12'd0, c.freq});
        reg_write(REG_DUTY,   {25'd0, c.duty});
        reg_write(REG_MOD_EN, {31'd0, c.mod_en});
        reg_write(REG_INVERT, {31'd0, c.invert});
        reg_write(REG_OFFSET, {24'd0, c.offset});
    endtask

    // fixed corner settings first, random ones later
    function automatic t_cfg pick_cfg(int p);
        t_cfg c;
        case (p)
            0: c = '{20'd38,      7'd50,  1'b1, 1'b0, 8'sd0};
            1: c = '{20'd0,       7'd0,   1'b1, 1'b1, -8'sd128};
            2: c = '{20'd1000000, 7'd127, 1'b1, 1'b0, 8'sd127};
            3: c = '{20'd1000000, 7'd50,  1'b1, 1'b1, -8'sd128};
            4: c = '{20'd56000,   7'd33,  1'b0, 1'b0, 8'sd5};
            default: begin
                case ($urandom_range(0, 3))
                    0: c.freq = 20'($urandom_range(20, 80));
                    1: c.freq = 20'($urandom_range(1000, 250000));
                    2: c.freq = 20'($urandom_range(0, 20'hFFFFF));
                    default: c.freq = 20'($urandom_range(0, 999));
                endcase
                c.duty   = 7'($urandom_range(0, 127));
                c.mod_en = $urandom_range(0, 3) != 0;
                c.invert = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 1) != 0) c.offset = 8'($urandom_range(0, 255));
                else c.offset = 8'(int'($urandom_range(0, 16)) - 8);
            end
        endcase
        return c;
    endfunction

    function automatic void add_item(logic [1:0] op, logic [15:0] dur);
        t_stim_row row;
        row               = '0;
        row.item.opcode   = op;
        row.item.duration = dur;
        stim_q.push_back(row);
    endfunction

    function automatic logic [15:0] pick_dur();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'd0;
        if (r < 85) return 16'($urandom_range(1, 30));
        return 16'($urandom_range(31, 150));
    endfunction

    // one mark or space with the ticks that run it out, and an occasional refused push or nop among them
    function automatic void add_interval(logic [15:0] dur);
        int refuse_at;
        add_item(OP_PUSH, dur);
        refuse_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 40)) : -1;
        for (int k = 0; k < int'(dur); k++) begin
            if (k == refuse_at) add_item(OP_PUSH, 16'($urandom));
            if ($urandom_range(0, 24) == 0) add_item(CMD_NOP, 16'($urandom));
            add_item(OP_TICK, 16'($urandom));
        end
        repeat ($urandom_range(0, 1)) add_item(OP_TICK, 16'($urandom));
    endfunction

    function automatic void build_frame(bit with_start);
        int pairs;
        if (with_start) add_item(OP_START, 16'($urandom));
        // long random mark cut short by a restart
        if ($urandom_range(0, 15) == 0) begin
            add_item(OP_PUSH, 16'($urandom));
            repeat ($urandom_range(0, 6)) add_item(OP_TICK, 16'($urandom));
            add_item(OP_START, 16'($urandom));
        end
        pairs = $urandom_range(1, 3);
        repeat (pairs) begin
            add_interval(pick_dur());
            if ($urandom_range(0, 19) == 0) add_item(OP_START, 16'($urandom));
            else add_interval(pick_dur());
        end
    endfunction

    task automatic drive_row(t_stim_row row);
        t_out_res want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= row.item;
        do @(posedge i_clk); while (in_stall);
        want = sender_step(row.item);
        pin_status_q.push_back(row.typed ? row.res : want);
    endtask

    // block is idle once every status is back
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pin_status_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        out_stall <= $urandom_range(0, 99) < recv_stall_pct;
    end

    always @(posedge i_clk) begin
        t_out_res want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pin_status_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected status item: %p", out_res);
            end else begin
                want = pin_status_q.pop_front();
                if (out_res.pin_level !== want.pin_level ||
                    out_res.busy_res !== want.busy_res ||
                    out_res.accepted !== want.accepted ||
                    out_res.in_mark !== want.in_mark ||
                    out_res.pulse_count !== want.pulse_count) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display({"status mismatch (exp/got): pin %0b/%0b busy %0b/%0b ",
                                  "acc %0b/%0b mark %0b/%0b pulses %0d/%0d"},
                                 want.pin_level, out_res.pin_level,
                                 want.busy_res, out_res.busy_res,
                                 want.accepted, out_res.accepted,
                                 want.in_mark, out_res.in_mark,
                                 want.pulse_count, out_res.pulse_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        regs       = '{20'd38000, 7'd50, 1'b1, 1'b0, 8'sd0};
        rem_us     = '0;
        pulse_cnt  = '0;
        phase_us   = '0;
        on_us      = '0;
        off_us     = '0;
        mark_on    = 1'b0;
        space_next = 1'b0;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 32;
        recv_stall_pct = 88;
        // short carrier (period 4, half duty) so the directed mark wraps twice
        apply_cfg('{20'd1000000, 7'd50, 1'b1, 1'b0, 8'sd3});
        foreach (dir_tab[i]) drive_row(dir_tab[i]);
        wait_drain();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p / 3)
                0: begin send_idle_pct = 32; recv_stall_pct = 88; end
                1: begin send_idle_pct = 88; recv_stall_pct = 32; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            apply_cfg(pick_cfg(p));
            stim_q.delete();
            build_frame(1'b1);
            while (stim_q.size() < PHASE_ITEMS) build_frame($urandom_range(0, 3) == 0);
            // trim the last frame so every phase sends the same count
            while (stim_q.size() > PHASE_ITEMS) void'(stim_q.pop_back());
            foreach (stim_q[i]) drive_row(stim_q[i]);
            wait_drain();
        end

        repeat (64) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
design/ircms_pkg.sv
design/ircms_front.sv
design/ircms_queue.sv
design/ircms_divider.sv
design/ircms_back.sv
design/ir_carrier_mark_space_sender.sv
bench/tb_ir_carrier_mark_space_sender.sv
